>>> rtl/coalescing_action_event_queue_macros.svh
// Assertion macros shared by the coalescing action event queue RTL.
`ifndef COALESCING_ACTION_EVENT_QUEUE_MACROS_SVH
`define COALESCING_ACTION_EVENT_QUEUE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CAEQ_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CAEQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/caeq_pkg.sv
// Types and constants of the coalescing action event queue.
package caeq_pkg;

    localparam int ID_W     = 31;
    localparam int BITS_W   = 32;
    localparam int TIME_W   = 48;
    localparam int TMO_W    = 16;
    localparam int STATUS_W = 3;
    localparam int QCNT_W   = 5;

    localparam int S_TDATA_W = 176;
    localparam int M_TDATA_W = 136;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    localparam logic [STATUS_W-1:0] ST_MERGED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_QUEUED  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_IGNORED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMITTED = 3'd4;
    localparam logic [STATUS_W-1:0] ST_EXPIRED = 3'd5;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd6;

    localparam logic FUNC_REPORT = 1'b0;
    localparam logic FUNC_TAKE   = 1'b1;

    localparam logic REG_ACTION_MASK = 1'b0;
    localparam logic REG_TIMEOUT_MS  = 1'b1;

    localparam logic [BITS_W-1:0] ACTION_MASK_RESET = 32'hFFFF_FFFF;
    localparam logic [TMO_W-1:0]  TIMEOUT_RESET     = 16'd3000;

    typedef logic [ID_W-1:0] id_t;

    typedef struct packed {
        id_t               user;
        id_t               device;
        id_t               channel;
        logic [BITS_W-1:0] actions;
        logic [TIME_W-1:0] stamp;
    } entry_t;

endpackage

>>> rtl/caeq_entry_ram.sv
// Entry storage: one write port, one read port with registered read data.
module caeq_entry_ram #(
    parameter int DEPTH = 16
) (
    input  logic                       aclk,
    input  logic [$clog2(DEPTH)-1:0]   rd_addr,
    output caeq_pkg::entry_t           rd_data,
    input  logic                       wr_en,
    input  logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  caeq_pkg::entry_t           wr_data
);
    import caeq_pkg::*;

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/coalescing_action_event_queue.sv
// Top level of the coalescing action event queue.
// Keeps a FIFO of action events keyed by user, device and channel in one entry RAM.
// A report searches the queued entries one per cycle through the RAM read port and
// merges into the entry whose key matches or, with no match, goes on to the append step;
// an invalid report or an empty take goes straight to its result, and a take
// reads the head entry. One result transaction follows every
// input transaction; a new input is taken while the previous result still waits
// on the master side, and the block stalls at its end until the output register
// frees. Configuration is an APB port: action_mask at 0x0, timeout_ms at 0x4.
`include "coalescing_action_event_queue_macros.svh"

module coalescing_action_event_queue #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // tdata: user, device, channel, action_bits, user_enabled, now_ms
    input  logic [caeq_pkg::S_TDATA_W-1:0]   s_tdata,
    // tuser: func
    input  logic                             s_tuser,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // tdata: out_user, out_device, out_channel, action_bit, queue_count
    output logic [caeq_pkg::M_TDATA_W-1:0]   m_tdata,
    // tuser: status
    output logic [caeq_pkg::STATUS_W-1:0]    m_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [caeq_pkg::APB_AW-1:0]      paddr,
    input  logic [caeq_pkg::APB_DW-1:0]      pwdata,
    output logic [caeq_pkg::APB_DW-1:0]      prdata,
    output logic                             pready
);
    import caeq_pkg::*;

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [IDX_W:0]   DEPTH_L = QUEUE_DEPTH[IDX_W:0];
    localparam logic [CNT_W-1:0] DEPTH_C = QUEUE_DEPTH[CNT_W-1:0];

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SEARCH = 3'd1;
    localparam logic [2:0] S_APPEND = 3'd2;
    localparam logic [2:0] S_TAKE   = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    function automatic logic [IDX_W-1:0] slot_of(logic [IDX_W-1:0] head,
                                                  logic [IDX_W-1:0] off);
        logic [IDX_W:0] sum;
        sum = {1'b0, head} + {1'b0, off};
        if (sum >= DEPTH_L) begin
            sum = sum - DEPTH_L;
        end
        return sum[IDX_W-1:0];
    endfunction

    logic [2:0]          state_reg, state_next;
    id_t                 user_reg, user_next;
    id_t                 dev_reg, dev_next;
    id_t                 chan_reg, chan_next;
    logic [BITS_W-1:0]   bits_reg, bits_next;
    logic                en_reg, en_next;
    logic [TIME_W-1:0]   now_reg, now_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [IDX_W-1:0]    head_reg, head_next;
    logic [CNT_W-1:0]    count_reg, count_next;

    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    id_t                 res_user_reg, res_user_next;
    id_t                 res_dev_reg, res_dev_next;
    id_t                 res_chan_reg, res_chan_next;
    logic [BITS_W-1:0]   res_bit_reg, res_bit_next;

    logic                m_tvalid_reg, m_tvalid_next;
    logic [STATUS_W-1:0] m_status_reg, m_status_next;
    id_t                 m_user_reg, m_user_next;
    id_t                 m_dev_reg, m_dev_next;
    id_t                 m_chan_reg, m_chan_next;
    logic [BITS_W-1:0]   m_bit_reg, m_bit_next;
    logic [QCNT_W-1:0]   m_count_reg, m_count_next;

    logic [BITS_W-1:0]   mask_reg;
    logic [TMO_W-1:0]    timeout_reg;

    logic [IDX_W-1:0]    rd_addr;
    entry_t              rd_data;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    entry_t              wr_data;

    id_t                 in_user, in_dev, in_chan;
    logic [BITS_W-1:0]   in_bits;
    logic                in_en;
    logic [TIME_W-1:0]   in_now;
    logic                s_accept;
    logic                key_match;
    logic [TIME_W-1:0]   age;
    logic [BITS_W-1:0]   low_bit, rest_bits;
    logic                count_held;
    logic                emit_pending;

    assign in_user  = s_tdata[30:0];
    assign in_dev   = s_tdata[61:31];
    assign in_chan  = s_tdata[92:62];
    assign in_bits  = s_tdata[124:93];
    assign in_en    = s_tdata[125];
    assign in_now   = s_tdata[173:126];

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;

    assign rd_addr = (state_reg == S_SEARCH) ? slot_of(head_reg, idx_reg + IDX_W'(1))
                                             : head_reg;

    assign key_match = (rd_data.user == user_reg) && (rd_data.device == dev_reg) &&
                       (rd_data.channel == chan_reg);
    assign age       = now_reg - rd_data.stamp;
    assign low_bit   = rd_data.actions & (~rd_data.actions + BITS_W'(1));
    assign rest_bits = rd_data.actions & ~low_bit;

    caeq_entry_ram #(
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    always_comb begin
        state_next      = state_reg;
        user_next       = user_reg;
        dev_next        = dev_reg;
        chan_next       = chan_reg;
        bits_next       = bits_reg;
        en_next         = en_reg;
        now_next        = now_reg;
        idx_next        = idx_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        res_status_next = res_status_reg;
        res_user_next   = res_user_reg;
        res_dev_next    = res_dev_reg;
        res_chan_next   = res_chan_reg;
        res_bit_next    = res_bit_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_status_next   = m_status_reg;
        m_user_next     = m_user_reg;
        m_dev_next      = m_dev_reg;
        m_chan_next     = m_chan_reg;
        m_bit_next      = m_bit_reg;
        m_count_next    = m_count_reg;
        wr_en           = 1'b0;
        wr_addr         = head_reg;
        wr_data         = rd_data;

        unique case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    user_next     = in_user;
                    dev_next      = in_dev;
                    chan_next     = in_chan;
                    bits_next     = in_bits & mask_reg;
                    en_next       = in_en;
                    now_next      = in_now;
                    idx_next      = '0;
                    res_user_next = '0;
                    res_dev_next  = '0;
                    res_chan_next = '0;
                    res_bit_next  = '0;
                    if (s_tuser == FUNC_TAKE) begin
                        if (count_reg == '0) begin
                            res_status_next = ST_EMPTY;
                            state_next      = S_DONE;
                        end else begin
                            state_next = S_TAKE;
                        end
                    end else if ((in_user == '0) || (in_dev == '0) || (in_chan == '0) ||
                                 ((in_bits & mask_reg) == '0)) begin
                        res_status_next = ST_IGNORED;
                        state_next      = S_DONE;
                    end else if (count_reg == '0) begin
                        state_next = S_APPEND;
                    end else begin
                        state_next = S_SEARCH;
                    end
                end
            end
            S_SEARCH: begin
                if (key_match) begin
                    wr_en           = 1'b1;
                    wr_addr         = slot_of(head_reg, idx_reg);
                    wr_data.actions = rd_data.actions | bits_reg;
                    wr_data.stamp   = now_reg;
                    res_status_next = ST_MERGED;
                    state_next      = S_DONE;
                end else if (CNT_W'(idx_reg) + CNT_W'(1) == count_reg) begin
                    state_next = S_APPEND;
                end else begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            S_APPEND: begin
                if (!en_reg) begin
                    res_status_next = ST_IGNORED;
                end else if (count_reg == DEPTH_C) begin
                    res_status_next = ST_FULL;
                end else begin
                    wr_en           = 1'b1;
                    wr_addr         = slot_of(head_reg, count_reg[IDX_W-1:0]);
                    wr_data.user    = user_reg;
                    wr_data.device  = dev_reg;
                    wr_data.channel = chan_reg;
                    wr_data.actions = bits_reg;
                    wr_data.stamp   = now_reg;
                    count_next      = count_reg + CNT_W'(1);
                    res_status_next = ST_QUEUED;
                end
                state_next = S_DONE;
            end
            S_TAKE: begin
                if (age >= TIME_W'(timeout_reg)) begin
                    res_status_next = ST_EXPIRED;
                    res_chan_next   = rd_data.channel;
                    head_next       = slot_of(head_reg, IDX_W'(1));
                    count_next      = count_reg - CNT_W'(1);
                end else begin
                    res_status_next = ST_EMITTED;
                    res_user_next   = rd_data.user;
                    res_dev_next    = rd_data.device;
                    res_chan_next   = rd_data.channel;
                    res_bit_next    = low_bit;
                    if (rest_bits != '0) begin
                        wr_en           = 1'b1;
                        wr_data.actions = rest_bits;
                    end else begin
                        head_next  = slot_of(head_reg, IDX_W'(1));
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_status_next = res_status_reg;
                    m_user_next   = res_user_reg;
                    m_dev_next    = res_dev_reg;
                    m_chan_next   = res_chan_reg;
                    m_bit_next    = res_bit_reg;
                    m_count_next  = QCNT_W'(count_reg);
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            head_reg     <= '0;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        user_reg       <= user_next;
        dev_reg        <= dev_next;
        chan_reg       <= chan_next;
        bits_reg       <= bits_next;
        en_reg         <= en_next;
        now_reg        <= now_next;
        idx_reg        <= idx_next;
        res_status_reg <= res_status_next;
        res_user_reg   <= res_user_next;
        res_dev_reg    <= res_dev_next;
        res_chan_reg   <= res_chan_next;
        res_bit_reg    <= res_bit_next;
        m_status_reg   <= m_status_next;
        m_user_reg     <= m_user_next;
        m_dev_reg      <= m_dev_next;
        m_chan_reg     <= m_chan_next;
        m_bit_reg      <= m_bit_next;
        m_count_reg    <= m_count_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg    <= ACTION_MASK_RESET;
            timeout_reg <= TIMEOUT_RESET;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                REG_ACTION_MASK: mask_reg    <= pwdata;
                REG_TIMEOUT_MS:  timeout_reg <= pwdata[TMO_W-1:0];
                default:         mask_reg    <= mask_reg;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_ACTION_MASK: prdata = mask_reg;
            REG_TIMEOUT_MS:  prdata = APB_DW'(timeout_reg);
            default:         prdata = '0;
        endcase
    end

    assign pready   = 1'b1;
    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {6'b0, m_count_reg, m_bit_reg, m_chan_reg, m_dev_reg, m_user_reg};

    // count moves only in the append and take states
    assign count_held   = (state_reg != S_APPEND) && (state_reg != S_TAKE);
    assign emit_pending = m_tvalid_reg && (m_status_reg == ST_EMITTED);

    `CAEQ_ASSERT_SAME(a_count_bound, aclk, aresetn, 1'b1, count_reg <= DEPTH_C, "count over depth")
    `CAEQ_ASSERT_NEXT(a_leave_idle, aclk, aresetn, s_accept, state_reg != S_IDLE, "stuck idle")
    `CAEQ_ASSERT_NEXT(a_count_held, aclk, aresetn, count_held, $stable(count_reg), "count moved")
    `CAEQ_ASSERT_SAME(a_onehot, aclk, aresetn, emit_pending, $onehot(m_bit_reg), "bit not one-hot")

endmodule
